// File: rtl/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define UTK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// clocked assertion that also holds during reset
`define UTK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/utk_pkg.sv
package utk_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned VecW = 40;
  localparam int unsigned AngW = 22;
  localparam int unsigned RotW = 20;
  localparam int unsigned ErrW = 33;

  localparam logic signed [AngW-1:0] AngPi     = AngW'(205887);
  localparam logic signed [AngW-1:0] AngHalfPi = AngW'(102944);
  localparam logic signed [AngW-1:0] AngTwoPi  = AngW'(411775);
  localparam logic signed [RotW-1:0] CordicInvGain = RotW'(39797);

  typedef enum logic [1:0] {
    REG_GAIN_ALONG   = 2'd0,
    REG_GAIN_LATERAL = 2'd1,
    REG_GAIN_HEADING = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [RotW-1:0] x;
    logic signed [RotW-1:0] y;
    logic signed [AngW-1:0] a;
  } rot_t;

  typedef struct packed {
    logic signed [ErrW-1:0] ex;
    logic signed [ErrW-1:0] ey;
    logic signed [15:0]     rh;
    logic signed [15:0]     vr;
    logic signed [15:0]     wr;
    logic                   zero;
    logic                   neg_y;
    logic                   neg_d;
  } side_t;

  function automatic logic signed [AngW-1:0] atan_lut(input int unsigned i);
    logic signed [AngW-1:0] r;
    case (i)
      0:       r = AngW'(51472);
      1:       r = AngW'(30386);
      2:       r = AngW'(16055);
      3:       r = AngW'(8150);
      4:       r = AngW'(4091);
      5:       r = AngW'(2047);
      6:       r = AngW'(1024);
      7:       r = AngW'(512);
      8:       r = AngW'(256);
      9:       r = AngW'(128);
      10:      r = AngW'(64);
      11:      r = AngW'(32);
      12:      r = AngW'(16);
      13:      r = AngW'(8);
      14:      r = AngW'(4);
      15:      r = AngW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [AngW-1:0] wrap_ang(input logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] r;
    r = a;
    if (a > AngPi) r = a - AngTwoPi;
    else if (a < -AngPi) r = a + AngTwoPi;
    return r;
  endfunction

  // round half up by 2^n, then clamp to 16 bits
  function automatic logic signed [15:0] rnd_sat16(input logic signed [63:0] v,
                                                   input int unsigned n);
    logic signed [63:0] r;
    logic signed [15:0] s;
    r = (v + (64'sd1 <<< (n - 1))) >>> n;
    if (r > 64'sd32767) s = 16'sh7fff;
    else if (r < -64'sd32768) s = 16'sh8000;
    else s = r[15:0];
    return s;
  endfunction

endpackage

// File: rtl/utk_if.sv
interface utk_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [15:0] ref_heading;
  logic signed [15:0] ref_speed;
  logic signed [15:0] ref_turn_rate;

  modport source (output valid, meas_x, meas_y, quat_x, quat_y, quat_z, quat_w,
                  ref_x, ref_y, ref_heading, ref_speed, ref_turn_rate, input ready);
  modport sink (input valid, meas_x, meas_y, quat_x, quat_y, quat_z, quat_w,
                ref_x, ref_y, ref_heading, ref_speed, ref_turn_rate, output ready);
endinterface

interface utk_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_speed;
  logic signed [15:0] cmd_turn_rate;

  modport source (output valid, cmd_speed, cmd_turn_rate, input ready);
  modport sink (input valid, cmd_speed, cmd_turn_rate, output ready);
endinterface

// File: rtl/utk_vec_stage.sv
module utk_vec_stage
  import utk_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  vec_t d_i,
  output logic vld_o,
  output vec_t q_o
);
  logic vld_q;
  vec_t q_q, d;
  logic signed [VecW-1:0] xs, ys;

  // one vectoring iteration, floor shifts
  always_comb begin
    xs = d_i.x >>> Idx;
    ys = d_i.y >>> Idx;
    if (d_i.y > 0) begin
      d.x = d_i.x + ys;
      d.y = d_i.y - xs;
      d.z = d_i.z + atan_lut(Idx);
    end else begin
      d.x = d_i.x - ys;
      d.y = d_i.y + xs;
      d.z = d_i.z - atan_lut(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= d;
  end

  assign vld_o = vld_q;
  assign q_o   = q_q;
endmodule

// File: rtl/utk_rot_stage.sv
module utk_rot_stage
  import utk_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  rot_t ry_i,
  input  rot_t rd_i,
  output logic vld_o,
  output rot_t ry_o,
  output rot_t rd_o
);
  logic vld_q;
  rot_t ry_q, rd_q;

  function automatic rot_t step(input rot_t r);
    rot_t o;
    logic signed [RotW-1:0] xs, ys;
    xs = r.x >>> Idx;
    ys = r.y >>> Idx;
    if (r.a >= 0) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.a = r.a - atan_lut(Idx);
    end else begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.a = r.a + atan_lut(Idx);
    end
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ry_q <= step(ry_i);
      rd_q <= step(rd_i);
    end
  end

  assign vld_o = vld_q;
  assign ry_o  = ry_q;
  assign rd_o  = rd_q;
endmodule

// File: rtl/unicycle_trajectory_tracking_law.sv
// unicycle trajectory tracking law, fixed point
// in_i carries one item per pose sample: measured position and quaternion
// plus the reference point (position, heading, speed, turn rate)
// out_o carries one item per input item: cmd_speed and cmd_turn_rate, Q4.12,
// saturated
// gains are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write them only while idle, the block itself does not enforce it
// throughput: one item per cycle while out_o is not stalled; the pipeline
// is 42 register stages, mostly two 16-stage cordic chains (yaw, then
// sin/cos of yaw and heading error); a receiver stall freezes the whole
// pipeline, in_i.ready drops in the same cycle, nothing is lost or repeated
// reset clears all valid bits and loads every gain with 1.0 (256)
module unicycle_trajectory_tracking_law
  import utk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  utk_in_if.sink      in_i,
  utk_out_if.source   out_o
);
  // global advance: a stage moves when the output is free or being taken
  logic en;
  logic vld_out_q;
  assign en = !vld_out_q || out_o.ready;
  assign in_i.ready = en;

  // gain registers
  logic [15:0] gain_along_q, gain_lateral_q, gain_heading_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_along_q   <= 16'd256;
      gain_lateral_q <= 16'd256;
      gain_heading_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_ALONG:   gain_along_q   <= cfg_data_i;
        REG_GAIN_LATERAL: gain_lateral_q <= cfg_data_i;
        REG_GAIN_HEADING: gain_heading_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: quaternion products and position error
  logic vld1_q;
  logic signed [31:0] p_wz_q, p_xy_q, p_yy_q, p_zz_q;
  side_t side1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else if (en) vld1_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wz_q <= in_i.quat_w * in_i.quat_z;
      p_xy_q <= in_i.quat_x * in_i.quat_y;
      p_yy_q <= in_i.quat_y * in_i.quat_y;
      p_zz_q <= in_i.quat_z * in_i.quat_z;
      side1_q.ex    <= ErrW'(in_i.ref_x) - ErrW'(in_i.meas_x);
      side1_q.ey    <= ErrW'(in_i.ref_y) - ErrW'(in_i.meas_y);
      side1_q.rh    <= in_i.ref_heading;
      side1_q.vr    <= in_i.ref_speed;
      side1_q.wr    <= in_i.ref_turn_rate;
      side1_q.zero  <= 1'b0;
      side1_q.neg_y <= 1'b0;
      side1_q.neg_d <= 1'b0;
    end
  end

  // stage 2: atan2 operands, quarter-turn pre-rotation for negative x
  logic signed [VecW-1:0] num, den;
  vec_t vec_d;
  side_t side2_d;
  always_comb begin
    num = (VecW'(p_wz_q) + VecW'(p_xy_q)) <<< 1;
    den = (VecW'(64'sd1) <<< 28) - ((VecW'(p_yy_q) + VecW'(p_zz_q)) <<< 1);
    side2_d = side1_q;
    side2_d.zero = (num == '0) && (den == '0);
    vec_d.x = den;
    vec_d.y = num;
    vec_d.z = '0;
    if (den < 0) begin
      if (num >= 0) begin
        vec_d.x = num;
        vec_d.y = -den;
        vec_d.z = AngHalfPi;
      end else begin
        vec_d.x = -num;
        vec_d.y = den;
        vec_d.z = -AngHalfPi;
      end
    end
  end

  logic  vec_vld [CordicSteps+1];
  vec_t  vec_q   [CordicSteps+1];
  side_t vside_q [CordicSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vec_vld[0] <= 1'b0;
    else if (en) vec_vld[0] <= vld1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_q[0]   <= vec_d;
      vside_q[0] <= side2_d;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_vec
    utk_vec_stage #(.Idx(i)) u_vec (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vec_vld[i]),
      .d_i   (vec_q[i]),
      .vld_o (vec_vld[i+1]),
      .q_o   (vec_q[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) vside_q[i+1] <= vside_q[i];
    end
  end

  // stage 3: yaw, heading error, fold both into the right half plane
  logic signed [AngW-1:0] yaw, ay, ad;
  rot_t ry_d, rd_d;
  side_t side3_d;
  always_comb begin
    side3_d = vside_q[CordicSteps];
    yaw = vside_q[CordicSteps].zero ? '0 : wrap_ang(vec_q[CordicSteps].z);
    ay  = wrap_ang(yaw);
    ad  = wrap_ang((AngW'(vside_q[CordicSteps].rh) <<< 3) - yaw);
    side3_d.neg_y = 1'b0;
    side3_d.neg_d = 1'b0;
    if (ay > AngHalfPi) begin
      ay = ay - AngPi;
      side3_d.neg_y = 1'b1;
    end else if (ay < -AngHalfPi) begin
      ay = ay + AngPi;
      side3_d.neg_y = 1'b1;
    end
    if (ad > AngHalfPi) begin
      ad = ad - AngPi;
      side3_d.neg_d = 1'b1;
    end else if (ad < -AngHalfPi) begin
      ad = ad + AngPi;
      side3_d.neg_d = 1'b1;
    end
    ry_d.x = CordicInvGain;
    ry_d.y = '0;
    ry_d.a = ay;
    rd_d.x = CordicInvGain;
    rd_d.y = '0;
    rd_d.a = ad;
  end

  logic  rot_vld [CordicSteps+1];
  rot_t  ry_q    [CordicSteps+1];
  rot_t  rd_q    [CordicSteps+1];
  side_t rside_q [CordicSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rot_vld[0] <= 1'b0;
    else if (en) rot_vld[0] <= vec_vld[CordicSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ry_q[0]    <= ry_d;
      rd_q[0]    <= rd_d;
      rside_q[0] <= side3_d;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    utk_rot_stage #(.Idx(i)) u_rot (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (rot_vld[i]),
      .ry_i  (ry_q[i]),
      .rd_i  (rd_q[i]),
      .vld_o (rot_vld[i+1]),
      .ry_o  (ry_q[i+1]),
      .rd_o  (rd_q[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) rside_q[i+1] <= rside_q[i];
    end
  end

  // stage 4: undo the half-turn fold
  logic vld4_q;
  logic signed [RotW-1:0] sy_q, cy_q, sd_q, cd_q;
  side_t side4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld4_q <= 1'b0;
    else if (en) vld4_q <= rot_vld[CordicSteps];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cy_q <= rside_q[CordicSteps].neg_y ? -ry_q[CordicSteps].x : ry_q[CordicSteps].x;
      sy_q <= rside_q[CordicSteps].neg_y ? -ry_q[CordicSteps].y : ry_q[CordicSteps].y;
      cd_q <= rside_q[CordicSteps].neg_d ? -rd_q[CordicSteps].x : rd_q[CordicSteps].x;
      sd_q <= rside_q[CordicSteps].neg_d ? -rd_q[CordicSteps].y : rd_q[CordicSteps].y;
      side4_q <= rside_q[CordicSteps];
    end
  end

  // stage 5: rotation products for the robot-frame error
  logic vld5_q;
  logic signed [53:0] cx_q, sxe_q, cye_q, sye_q;
  logic signed [RotW-1:0] sd5_q, cd5_q;
  side_t side5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld5_q <= 1'b0;
    else if (en) vld5_q <= vld4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q  <= 54'(cy_q) * 54'(side4_q.ex);
      sye_q <= 54'(sy_q) * 54'(side4_q.ey);
      cye_q <= 54'(cy_q) * 54'(side4_q.ey);
      sxe_q <= 54'(sy_q) * 54'(side4_q.ex);
      sd5_q <= sd_q;
      cd5_q <= cd_q;
      side5_q <= side4_q;
    end
  end

  // stage 6: robot-frame error, rounded half up to Q.16
  logic vld6_q;
  logic signed [37:0] lx_q, ly_q;
  logic signed [54:0] lx_full, ly_full;
  logic signed [RotW-1:0] sd6_q, cd6_q;
  side_t side6_q;
  assign lx_full = ((55'(cx_q) + 55'(sye_q)) + 55'sd32768) >>> 16;
  assign ly_full = ((55'(cye_q) - 55'(sxe_q)) + 55'sd32768) >>> 16;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld6_q <= 1'b0;
    else if (en) vld6_q <= vld5_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      lx_q <= lx_full[37:0];
      ly_q <= ly_full[37:0];
      sd6_q <= sd5_q;
      cd6_q <= cd5_q;
      side6_q <= side5_q;
    end
  end

  // stage 7: gain products
  logic vld7_q;
  logic signed [63:0] vcd_q, kxl_q, kyl_q, kts_q;
  side_t side7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld7_q <= 1'b0;
    else if (en) vld7_q <= vld6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      vcd_q <= 64'(side6_q.vr) * 64'(cd6_q);
      kxl_q <= 64'($signed({1'b0, gain_along_q})) * 64'(lx_q);
      kyl_q <= 64'($signed({1'b0, gain_lateral_q})) * 64'(ly_q);
      kts_q <= 64'($signed({1'b0, gain_heading_q})) * 64'(sd6_q);
      side7_q <= side6_q;
    end
  end

  // stage 8: speed sum, inner turn term clamped to +-2^40
  logic vld8_q;
  logic signed [63:0] vsum_q, inner_s;
  logic signed [41:0] inner_q;
  side_t side8_q;
  localparam logic signed [63:0] InnerLim = 64'sd1 <<< 40;
  assign inner_s = kyl_q + kts_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld8_q <= 1'b0;
    else if (en) vld8_q <= vld7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      vsum_q <= vcd_q + (kxl_q <<< 4);
      if (inner_s > InnerLim) inner_q <= InnerLim[41:0];
      else if (inner_s < -InnerLim) inner_q <= 42'(-InnerLim);
      else inner_q <= inner_s[41:0];
      side8_q <= side7_q;
    end
  end

  // stage 9: speed rounded and saturated, turn product
  logic vld9_q;
  logic signed [15:0] v9_q;
  logic signed [63:0] vin_q;
  logic signed [15:0] wr9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld9_q <= 1'b0;
    else if (en) vld9_q <= vld8_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      v9_q  <= rnd_sat16(vsum_q, 16);
      vin_q <= 64'(side8_q.vr) * 64'(inner_q);
      wr9_q <= side8_q.wr;
    end
  end

  // stage 10: turn rate sum, round, saturate into the output register
  logic signed [15:0] v_out_q, w_out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_out_q <= 1'b0;
    else if (en) vld_out_q <= vld9_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      v_out_q <= v9_q;
      w_out_q <= rnd_sat16((64'(wr9_q) <<< 24) + vin_q, 24);
    end
  end

  assign out_o.valid         = vld_out_q;
  assign out_o.cmd_speed     = v_out_q;
  assign out_o.cmd_turn_rate = w_out_q;
endmodule

// File: rtl/utk_checker.sv
`include "assert_macros.svh"

module utk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data
);
  // a stalled result holds
  `UTK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  // input side is open exactly when the output register is free or drains
  `UTK_ASSERT(a_ready_link, clk_i, rst_ni, in_ready == (!out_valid || out_ready), "input ready does not follow output")
  // a new result appears only through an advance of the pipeline, never during a stall
  `UTK_ASSERT(a_rise_adv, clk_i, rst_ni, $rose(out_valid) |-> $past(in_ready), "result appeared during a stall")
  // no result is shown while in reset
  `UTK_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid, "result valid during reset")
endmodule

bind unicycle_trajectory_tracking_law utk_checker u_utk_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_data ({out_o.cmd_speed, out_o.cmd_turn_rate})
);

// File: dv/unicycle_trajectory_tracking_law_tb.sv
`timescale 1ns / 100ps

module unicycle_trajectory_tracking_law_tb;
  import utk_pkg::*;

  localparam int unsigned ClkHalf = 6;
  localparam int unsigned PipeDepth = 42;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 310;
  localparam logic [1:0] RegUnused = 2'd3;

  // fixed point constants of the tracking law, Q.16 angles
  localparam longint KPi = 205887;
  localparam longint KHalfPi = 102944;
  localparam longint KTwoPi = 411775;
  localparam longint KInvGain = 39797;

  typedef struct {
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [15:0] ref_heading;
    logic signed [15:0] ref_speed;
    logic signed [15:0] ref_turn_rate;
  } pose_item_t;

  typedef struct {
    logic signed [15:0] cmd_speed;
    logic signed [15:0] cmd_turn_rate;
  } cmd_item_t;

  // golden model of the control law plus the queue of expected commands
  class tracking_scoreboard;
    logic [15:0] kx, ky, kth;
    cmd_item_t   cmd_queue[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      kx = 16'd256;
      ky = 16'd256;
      kth = 16'd256;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_gain(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_GAIN_ALONG:   kx = val;
        REG_GAIN_LATERAL: ky = val;
        REG_GAIN_HEADING: kth = val;
        default: ;
      endcase
    endfunction

    function longint atan_step(int i);
      longint tbl[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
      return tbl[i];
    endfunction

    function longint wrap(longint a);
      if (a > KPi) return a - KTwoPi;
      if (a < -KPi) return a + KTwoPi;
      return a;
    endfunction

    // vectoring cordic, quarter turn first when x is negative
    function longint heading_of(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = KHalfPi;
        end else begin
          t = x; x = -y; y = t; z = -KHalfPi;
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atan_step(i);
        end else begin
          x -= ys; y += xs; z -= atan_step(i);
        end
      end
      return wrap(z);
    endfunction

    function void sin_cos(longint a, output longint s, output longint c);
      longint x, y, xs, ys;
      bit flip;
      x = KInvGain;
      y = 0;
      flip = 0;
      a = wrap(a);
      if (a > KHalfPi) begin
        a -= KPi; flip = 1;
      end else if (a < -KHalfPi) begin
        a += KPi; flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (a >= 0) begin
          x -= ys; y += xs; a -= atan_step(i);
        end else begin
          x += ys; y -= xs; a += atan_step(i);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function logic signed [15:0] round_clamp(longint v, int n);
      longint r;
      r = (v + (longint'(1) <<< (n - 1))) >>> n;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_input(pose_item_t it);
      longint qx, qy, qz, qw, num, den, yaw, sy, cy, sd, cd;
      longint ex, ey, lx, ly, vr, wr, v, inner, w;
      cmd_item_t c;
      qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
      num = 2 * (qw * qz + qx * qy);
      den = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
      yaw = heading_of(num, den);
      sin_cos(yaw, sy, cy);
      sin_cos(longint'(it.ref_heading) * 8 - yaw, sd, cd);
      ex = longint'(it.ref_x) - longint'(it.meas_x);
      ey = longint'(it.ref_y) - longint'(it.meas_y);
      // error in the robot frame, rounded half up
      lx = (cy * ex + sy * ey + 32768) >>> 16;
      ly = (cy * ey - sy * ex + 32768) >>> 16;
      vr = it.ref_speed;
      wr = it.ref_turn_rate;
      v = vr * cd + longint'(kx) * lx * 16;
      inner = longint'(ky) * ly + longint'(kth) * sd;
      if (inner > (longint'(1) <<< 40)) inner = longint'(1) <<< 40;
      if (inner < -(longint'(1) <<< 40)) inner = -(longint'(1) <<< 40);
      w = wr * (longint'(1) <<< 24) + vr * inner;
      c.cmd_speed = round_clamp(v, 16);
      c.cmd_turn_rate = round_clamp(w, 24);
      cmd_queue.insert(cmd_queue.size(), c);
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(cmd_item_t got);
      cmd_item_t want;
      if (cmd_queue.size() == 0) begin
        report($sformatf("unexpected command speed=%0d turn=%0d",
                         got.cmd_speed, got.cmd_turn_rate));
        return;
      end
      want = cmd_queue.pop_front();
      checked++;
      if (got.cmd_speed !== want.cmd_speed)
        report($sformatf("cmd_speed got %0d want %0d", got.cmd_speed, want.cmd_speed));
      if (got.cmd_turn_rate !== want.cmd_turn_rate)
        report($sformatf("cmd_turn_rate got %0d want %0d",
                         got.cmd_turn_rate, want.cmd_turn_rate));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b1;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  utk_in_if  pose_if ();
  utk_out_if cmd_if ();

  unicycle_trajectory_tracking_law i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pose_if.sink),
    .out_o      (cmd_if.source)
  );

  tracking_scoreboard sb = new();

  int unsigned cycles;
  int unsigned sent;
  bit          quiet;  // phase without idling on either side

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d commands outstanding", cycles,
               sb.cmd_queue.size());
      $display("[unicycle_trajectory_tracking_law] ERROR");
      $finish;
    end
  end

  // monitors: note every accepted pose item, check every accepted command
  always @(posedge clk_i) begin
    pose_item_t it;
    cmd_item_t  c;
    if (rst_ni && pose_if.valid && pose_if.ready) begin
      it.meas_x = pose_if.meas_x;           it.meas_y = pose_if.meas_y;
      it.quat_x = pose_if.quat_x;           it.quat_y = pose_if.quat_y;
      it.quat_z = pose_if.quat_z;           it.quat_w = pose_if.quat_w;
      it.ref_x = pose_if.ref_x;             it.ref_y = pose_if.ref_y;
      it.ref_heading = pose_if.ref_heading; it.ref_speed = pose_if.ref_speed;
      it.ref_turn_rate = pose_if.ref_turn_rate;
      sb.note_input(it);
    end
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      c.cmd_speed = cmd_if.cmd_speed;
      c.cmd_turn_rate = cmd_if.cmd_turn_rate;
      sb.check_result(c);
    end
  end

  // receiver with random back pressure
  initial begin
    int unsigned stall;
    cmd_if.ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        cmd_if.ready <= 1'b0;
        stall--;
      end else begin
        cmd_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic write_gain(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_gain(idx, val);
  endtask

  // hold valid until the item is taken; gaps go in front of the item
  task automatic send_pose(pose_item_t it);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      pose_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pose_if.valid <= 1'b1;
    pose_if.meas_x <= it.meas_x;           pose_if.meas_y <= it.meas_y;
    pose_if.quat_x <= it.quat_x;           pose_if.quat_y <= it.quat_y;
    pose_if.quat_z <= it.quat_z;           pose_if.quat_w <= it.quat_w;
    pose_if.ref_x <= it.ref_x;             pose_if.ref_y <= it.ref_y;
    pose_if.ref_heading <= it.ref_heading; pose_if.ref_speed <= it.ref_speed;
    pose_if.ref_turn_rate <= it.ref_turn_rate;
    do @(posedge clk_i); while (!pose_if.ready);
    sent++;
  endtask

  task automatic drain();
    pose_if.valid <= 1'b0;
    while (sb.cmd_queue.size() > 0) @(posedge clk_i);
    repeat (PipeDepth + 8) @(posedge clk_i);
  endtask

  function automatic pose_item_t make_pose(logic signed [31:0] mx, logic signed [31:0] my,
                                           logic signed [15:0] qx, logic signed [15:0] qy,
                                           logic signed [15:0] qz, logic signed [15:0] qw,
                                           logic signed [31:0] rx, logic signed [31:0] ry,
                                           logic signed [15:0] rh, logic signed [15:0] vr,
                                           logic signed [15:0] wr);
    pose_item_t it;
    it.meas_x = mx; it.meas_y = my;
    it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
    it.ref_x = rx; it.ref_y = ry;
    it.ref_heading = rh; it.ref_speed = vr; it.ref_turn_rate = wr;
    return it;
  endfunction

  // random pose: mostly a plausible robot near its reference, some raw bit noise
  function automatic pose_item_t random_pose();
    pose_item_t it;
    int unsigned mode;
    int          spread;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      spread = (mode < 4) ? 16'hffff : 32'h7fffff;
      it.meas_x = $urandom;
      it.meas_y = $urandom;
      it.ref_x = it.meas_x + $signed($urandom_range(0, 2 * spread)) - spread;
      it.ref_y = it.meas_y + $signed($urandom_range(0, 2 * spread)) - spread;
      it.quat_x = 16'($signed($urandom_range(0, 2048)) - 1024);
      it.quat_y = 16'($signed($urandom_range(0, 2048)) - 1024);
      it.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
      it.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
      it.ref_heading = 16'($signed($urandom_range(0, 51472)) - 25736);
      it.ref_speed = 16'($signed($urandom_range(0, 16384)) - 8192);
      it.ref_turn_rate = 16'($signed($urandom_range(0, 16384)) - 8192);
    end else begin
      it.meas_x = $urandom;  it.meas_y = $urandom;
      it.ref_x = $urandom;   it.ref_y = $urandom;
      it.quat_x = 16'($urandom);  it.quat_y = 16'($urandom);
      it.quat_z = 16'($urandom);  it.quat_w = 16'($urandom);
      it.ref_heading = 16'($urandom);
      it.ref_speed = 16'($urandom);
      it.ref_turn_rate = 16'($urandom);
    end
    return it;
  endfunction

  initial begin
    logic [15:0] gain_set[5][3];
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_GAIN_ALONG;
    cfg_data_i = '0;
    pose_if.valid = 1'b0;
    pose_if.meas_x = '0;  pose_if.meas_y = '0;
    pose_if.quat_x = '0;  pose_if.quat_y = '0;
    pose_if.quat_z = '0;  pose_if.quat_w = 16'sd16384;
    pose_if.ref_x = '0;   pose_if.ref_y = '0;
    pose_if.ref_heading = '0;
    pose_if.ref_speed = '0;
    pose_if.ref_turn_rate = '0;
    cycles = 0;
    sent = 0;
    quiet = 1'b0;
    // reset goes low ahead of the first clock edge
    #1 rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gains of 1.0
    send_pose(make_pose(0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0));
    send_pose(make_pose(0, 0, 0, 0, 0, 16384, 32'sh10000, 0, 0, 16'sh1000, 0));
    // degenerate quaternion, both atan2 terms zero
    send_pose(make_pose(0, 0, 0, 8192, 8192, 0, 32'sh8000, 32'sh8000, 25736, 4096, 4096));
    // yaw of pi (x term negative), then yaw near minus and plus a quarter turn
    send_pose(make_pose(0, 0, 0, 0, 16384, 0, 32'sh20000, 0, -25736, -4096, 0));
    send_pose(make_pose(0, 0, 0, 0, -16384, 0, 0, 32'sh20000, 25736, 4096, 0));
    send_pose(make_pose(0, 0, 0, 0, 11585, -11585, 32'sh10000, -32'sh10000, 12868, 8192, -8192));
    send_pose(make_pose(0, 0, 0, 0, -11585, -11585, 0, 0, -12868, 2048, 2048));
    // field extremes and saturation
    send_pose(make_pose(32'sh7fffffff, 32'sh80000000, 16384, -16384, 16384, -16384,
                        32'sh80000000, 32'sh7fffffff, 25736, 32767, 32767));
    send_pose(make_pose(32'sh80000000, 32'sh7fffffff, -16384, 16384, -16384, 16384,
                        32'sh7fffffff, 32'sh80000000, -25736, -32768, -32768));
    send_pose(make_pose(-1, -1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        -1, -1, 16'sh7fff, 32767, -32768));
    send_pose(make_pose(0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        0, 0, 16'sh8000, -32768, 32767));
    send_pose(make_pose(0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 32767));
    send_pose(make_pose(0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, -32768));
    drain();

    // gain phases: reset values, all zero, all maximum, then random
    gain_set[0] = '{16'd256, 16'd256, 16'd256};
    gain_set[1] = '{16'd0, 16'd0, 16'd0};
    gain_set[2] = '{16'hffff, 16'hffff, 16'hffff};
    for (int p = 3; p < 5; p++)
      for (int g = 0; g < 3; g++) gain_set[p][g] = 16'($urandom_range(0, 16'hffff));

    for (int p = 0; p < 5; p++) begin
      write_gain(REG_GAIN_ALONG, gain_set[p][0]);
      write_gain(REG_GAIN_LATERAL, gain_set[p][1]);
      write_gain(REG_GAIN_HEADING, gain_set[p][2]);
      // unused index must leave the gains alone
      write_gain(RegUnused, 16'($urandom));
      quiet = (p == 1);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n % 60 == 59) quiet = ~quiet;
        send_pose(random_pose());
      end
      quiet = 1'b0;
      drain();
    end

    $display("%0d pose items sent over 5 gain settings, %0d commands checked",
             sent, sb.checked);
    if (sb.mismatches == 0)
      $display("[unicycle_trajectory_tracking_law] OK");
    else
      $display("[unicycle_trajectory_tracking_law] ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/utk_pkg.sv
rtl/utk_if.sv
rtl/utk_vec_stage.sv
rtl/utk_rot_stage.sv
rtl/unicycle_trajectory_tracking_law.sv
rtl/utk_checker.sv
dv/unicycle_trajectory_tracking_law_tb.sv
